// ===== rtl/core/gb3c_pkg.sv =====
// gb3c_pkg: shared types, constants and the kernel arithmetic of the 3x3 blur
// no dependencies; used by every module of the block but gb3c_ram
package gb3c_pkg;

	localparam int PIX_W      = 24;
	localparam int LINE_W     = 2 * PIX_W;
	localparam int FW_W       = 11;
	localparam int FH_W       = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int MAX_HEIGHT = 4096;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;

	localparam logic [FW_W-1:0] FW_RESET = 11'd640;
	localparam logic [FH_W-1:0] FH_RESET = 13'd480;
	localparam logic            CM_RESET = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;

	// one window column, rows above, at and below the output row
	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} col_t;

	// per-item control carried down the pipeline
	typedef struct packed {
		logic emit;
		logic left;
		logic right;
		logic top;
		logic bot;
		logic fend;
	} flag_t;

	// weighted sum [1 2 1; 2 4 2; 1 2 1] of one channel, divided by 16
	function automatic logic [7:0] blur_chan(input col_t l, input col_t c, input col_t r,
		input logic [1:0] k);
		logic [4:0]  base;
		logic [11:0] corners;
		logic [11:0] edges;
		logic [11:0] sum;
		base    = {k, 3'b000};
		corners = 12'(l.top[base +: 8]) + 12'(r.top[base +: 8])
			+ 12'(l.bot[base +: 8]) + 12'(r.bot[base +: 8]);
		edges   = 12'(c.top[base +: 8]) + 12'(l.mid[base +: 8])
			+ 12'(r.mid[base +: 8]) + 12'(c.bot[base +: 8]);
		sum     = corners + (edges << 1) + (12'(c.mid[base +: 8]) << 2);
		return sum[11:4];
	endfunction

endpackage

// ===== rtl/core/gaussian_blur_3x3_clamp_top.sv =====
// gaussian_blur_3x3_clamp_top: streaming 3x3 gaussian blur with edge clamp
// depends on gb3c_pkg, gb3c_line, gb3c_cell
//
// Raster-order pixels of up to three 8-bit channels go in, blurred pixels come
// out in the same order, one per clock sustained: a new item can be taken every
// cycle, and a result waiting on a stalled output does not stop the input side
// unless the pipeline behind it is full. The result for pixel i leaves with
// the transfer of input item i+W+1 (i+W in a single-row frame); it is presented
// in the output register, after passing the input register (line read at the
// transfer edge) and the window shift.
// After the last pixel of a frame the remaining W+1 results (W in a single-row
// frame) are pushed out by further items, one result per item (flush ticks, or
// pixels whose data is dropped); the frame's last result carries frame_end,
// after which the next pixel starts a new frame. Flush ticks sent while a
// frame is still arriving are dropped. A config write aborts the current frame
// and must only be made while the block is idle. The two row delays live in
// one ram of MAX_WIDTH words of two pixels each, with one read and one write
// port; it needs no clearing pass after reset, since border pixels are rebuilt
// from the nearest edge pixel and stale words are never used. in_stall follows
// out_stall in the same cycle when every stage is full.
module gaussian_blur_3x3_clamp_top #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gb3c_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gb3c_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              kind,
	input  logic [7:0]                        chan_a,
	input  logic [7:0]                        chan_b,
	input  logic [7:0]                        chan_c,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [7:0]                        blur_a,
	output logic [7:0]                        blur_b,
	output logic [7:0]                        blur_c,
	output logic                              frame_end
);
	import gb3c_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);

	// configuration registers
	logic [FW_W-1:0] fw_q;
	logic [FH_W-1:0] fh_q;
	logic            cm_q;
	logic            cfg_hit;

	// effective geometry and row delay length
	logic [WW-1:0]   w_eff;
	logic [FH_W-1:0] h_eff;
	logic [WW-1:0]   delay_len;
	logic            delay_zero;

	// frame position counters
	logic [CW-1:0]   in_col_q;
	logic [FH_W-1:0] in_row_q;
	logic [CW-1:0]   out_col_q;
	logic [11:0]     out_row_q;
	logic [WW-1:0]   in_col_inc;
	logic [WW-1:0]   out_col_inc;
	logic [FH_W-1:0] out_row_inc;

	// item decode at the input transfer
	logic  acc;
	logic  draining;
	logic  adv;
	logic  emit_now;
	logic  fend_now;
	flag_t flags_now;

	// pipeline
	logic          valid_s1;
	pix_t          pix_s1;
	flag_t         flags_s1;
	logic          valid_s2;
	flag_t         flags_s2;
	logic          valid_s3;
	logic [7:0]    blur_a_s3;
	logic [7:0]    blur_b_s3;
	logic [7:0]    blur_c_s3;
	logic          fend_s3;
	logic          s1_free;
	logic          s2_free;
	logic          out_free;
	logic          mv2;
	logic          mv3;

	// line store and window
	logic [LINE_W-1:0] line_q;
	col_t              col_new;
	col_t              win_q [3];
	col_t              win_v [3];
	col_t              win_in [3];
	col_t              left_col;
	col_t              right_col;

	// ------------------------------------------------------------------
	// configuration
	// ------------------------------------------------------------------
	assign cfg_hit = cfg_we && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT
		|| cfg_index == CFG_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FW_RESET;
			fh_q <= FH_RESET;
			cm_q <= CM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH: begin
					fw_q <= cfg_data[FW_W-1:0];
				end
				CFG_HEIGHT: begin
					fh_q <= cfg_data[FH_W-1:0];
				end
				CFG_MODE: begin
					cm_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// out-of-range sizes fold onto the nearest legal size
	always_comb begin
		if (fw_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(fw_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(fw_q);
		end
		if (fh_q == '0) begin
			h_eff = FH_W'(1);
		end else if (32'(fh_q) > MAX_HEIGHT) begin
			h_eff = FH_W'(MAX_HEIGHT);
		end else begin
			h_eff = fh_q;
		end
	end

	// single-row frames run the middle row one column earlier
	assign delay_len  = (h_eff == FH_W'(1)) ? (w_eff - WW'(1)) : w_eff;
	assign delay_zero = (delay_len == '0);

	// ------------------------------------------------------------------
	// input decode and frame counters
	// ------------------------------------------------------------------
	assign acc      = in_valid && !in_stall;
	assign draining = (in_row_q >= h_eff);
	// every pixel, and every item once the frame is in, moves the window
	assign adv      = acc && (draining || !kind);
	// a result is due once pixel W+1 of the frame has arrived
	assign emit_now = adv && (draining || in_row_q >= FH_W'(2)
		|| (in_row_q == FH_W'(1) && in_col_q != '0));

	assign in_col_inc  = WW'(in_col_q) + WW'(1);
	assign out_col_inc = WW'(out_col_q) + WW'(1);
	assign out_row_inc = {1'b0, out_row_q} + FH_W'(1);
	assign fend_now    = (out_col_inc >= w_eff) && (out_row_inc >= h_eff);

	always_comb begin
		flags_now.emit  = emit_now;
		flags_now.left  = (out_col_q == '0);
		flags_now.right = (out_col_inc == w_eff);
		flags_now.top   = (out_row_q == '0);
		flags_now.bot   = (out_row_inc == h_eff);
		flags_now.fend  = fend_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_hit || (emit_now && fend_now)) begin
			// config write or end of frame: start over
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (adv) begin
			if (!draining) begin
				if (in_col_inc >= w_eff) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + FH_W'(1);
				end else begin
					in_col_q <= CW'(in_col_inc);
				end
			end
			if (emit_now) begin
				if (out_col_inc >= w_eff) begin
					out_col_q <= '0;
					out_row_q <= out_row_inc[11:0];
				end else begin
					out_col_q <= CW'(out_col_inc);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// pipeline handshake
	// ------------------------------------------------------------------
	assign out_free = !valid_s3 || !out_stall;
	assign s2_free  = !valid_s2 || !flags_s2.emit || out_free;
	assign s1_free  = !valid_s1 || s2_free;
	assign mv2      = valid_s1 && s2_free;
	assign mv3      = valid_s2 && flags_s2.emit && out_free;
	assign in_stall = !s1_free;

	// stage 1: input register, line read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			flags_s1 <= '0;
		end else begin
			if (s1_free) begin
				valid_s1 <= adv;
			end
			if (adv) begin
				flags_s1 <= flags_now;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1 <= {chan_c, chan_b, chan_a};
		end
	end

	// two row delays: lower half the row above the incoming one, upper half two above
	gb3c_line #(
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (adv),
		.clear  (cfg_hit || (emit_now && fend_now)),
		.depth  (delay_len),
		.wr     (mv2),
		.wr_data({col_new.mid, pix_s1}),
		.rd_data(line_q)
	);

	always_comb begin
		col_new.bot = pix_s1;
		col_new.mid = delay_zero ? pix_s1 : line_q[PIX_W-1:0];
		col_new.top = delay_zero ? pix_s1 : line_q[LINE_W-1:PIX_W];
	end

	// stage 2: chain of window columns, right cell takes the new column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			flags_s2 <= '0;
		end else begin
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (mv2) begin
				flags_s2 <= flags_s1;
			end
		end
	end

	assign win_in[2] = col_new;
	assign win_in[1] = win_q[2];
	assign win_in[0] = win_q[1];

	for (genvar i = 0; i < 3; i++) begin : g_win
		gb3c_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (mv2),
			.col_in   (win_in[i]),
			.top_clamp(flags_s2.top),
			.bot_clamp(flags_s2.bot),
			.col_q    (win_q[i]),
			.col_vert (win_v[i])
		);
	end

	// columns outside the frame take the center column
	assign left_col  = flags_s2.left ? win_v[1] : win_v[0];
	assign right_col = flags_s2.right ? win_v[1] : win_v[2];

	// stage 3: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (out_free) begin
			valid_s3 <= valid_s2 && flags_s2.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (mv3) begin
			blur_a_s3 <= blur_chan(left_col, win_v[1], right_col, 2'd0);
			blur_b_s3 <= cm_q ? blur_chan(left_col, win_v[1], right_col, 2'd1) : 8'd0;
			blur_c_s3 <= cm_q ? blur_chan(left_col, win_v[1], right_col, 2'd2) : 8'd0;
			fend_s3   <= flags_s2.fend;
		end
	end

	assign out_valid = valid_s3;
	assign blur_a    = blur_a_s3;
	assign blur_b    = blur_b_s3;
	assign blur_c    = blur_c_s3;
	assign frame_end = fend_s3;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// the frame's last result leaves every counter at the frame origin
	a_fend_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_now && fend_now) |=> (in_col_q == '0 && in_row_q == '0
			&& out_col_q == '0 && out_row_q == '0))
		else $error("counters not cleared after the last result of a frame");

	// a config write aborts the frame
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> (in_col_q == '0 && in_row_q == '0
			&& out_col_q == '0 && out_row_q == '0))
		else $error("counters not cleared after a config write");

	// no result is due before the second row has started
	a_emit_lag: assert property (@(posedge clk) disable iff (!arst_n)
		emit_now |-> (in_row_q != '0))
		else $error("result scheduled before its lower neighbors arrived");

	// an empty input stage always takes a transfer
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with an empty input stage");

endmodule

// ===== rtl/core/gb3c_ram.sv =====
// gb3c_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module gb3c_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old word when both ports hit one address
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/gb3c_line.sv =====
// gb3c_line: two chained row delays packed in one ram word, with a ring pointer
// depends on gb3c_pkg and gb3c_ram
module gb3c_line #(
	parameter int DEPTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              rd,
	input  logic                              clear,
	input  logic [$clog2(DEPTH + 1)-1:0]      depth,
	input  logic                              wr,
	input  logic [gb3c_pkg::LINE_W-1:0]       wr_data,
	output logic [gb3c_pkg::LINE_W-1:0]       rd_data
);
	import gb3c_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DW = $clog2(DEPTH + 1);

	logic [AW-1:0]     ptr_q;
	logic [AW-1:0]     last_q;
	logic [DW-1:0]     ptr_inc;
	logic [AW-1:0]     ptr_next;
	logic              fwd_q;
	logic [LINE_W-1:0] fwd_data_q;
	logic [LINE_W-1:0] ram_q;

	assign ptr_inc  = DW'(ptr_q) + DW'(1);
	assign ptr_next = (ptr_inc >= depth) ? '0 : AW'(ptr_inc);

	// write lands where the item now in flight was read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			last_q <= '0;
			fwd_q  <= 1'b0;
		end else begin
			if (rd) begin
				last_q <= ptr_q;
				ptr_q  <= clear ? '0 : ptr_next;
				fwd_q  <= wr && (last_q == ptr_q);
			end else if (clear) begin
				ptr_q <= '0;
			end
		end
	end

	// one-row delay: read and write of neighbors meet at one address
	always_ff @(posedge clk) begin
		if (rd) begin
			fwd_data_q <= wr_data;
		end
	end

	gb3c_ram #(
		.WIDTH(LINE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr),
		.waddr(last_q),
		.wdata(wr_data),
		.re   (rd),
		.raddr(ptr_q),
		.rdata(ram_q)
	);

	assign rd_data = fwd_q ? fwd_data_q : ram_q;

endmodule

// ===== rtl/core/gb3c_cell.sv =====
// gb3c_cell: one column of the 3x3 window, shifts to its left neighbor
// depends on gb3c_pkg
module gb3c_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift,
	input  gb3c_pkg::col_t col_in,
	input  logic           top_clamp,
	input  logic           bot_clamp,
	output gb3c_pkg::col_t col_q,
	output gb3c_pkg::col_t col_vert
);
	import gb3c_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	// rows outside the frame take the middle row
	always_comb begin
		col_vert     = col_q;
		if (top_clamp) begin
			col_vert.top = col_q.mid;
		end
		if (bot_clamp) begin
			col_vert.bot = col_q.mid;
		end
	end

endmodule
